// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL files that check their own behavior (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/clr_pkg.sv =====
// Shared constants for the clipped line rasterizer.
package clr_pkg;

    localparam int COORD_BITS_DEFAULT = 10;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_ENABLE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_LEFT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_RIGHT    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_TOP      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_BOTTOM   = 3'd6;

    // Reset values of the screen size
    localparam int SCREEN_WIDTH_RESET  = 128;
    localparam int SCREEN_HEIGHT_RESET = 64;

    // Input word modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

endpackage

// ===== hdl/clr_if.sv =====
// Channel interfaces: line commands in, pixels out, configuration writes.
interface clr_in_if
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic                  white;

    modport source (output valid, mode, x_start, y_start, x_end, y_end, white, input ready);
    modport sink   (input valid, mode, x_start, y_start, x_end, y_end, white, output ready);
endinterface

interface clr_out_if
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  visible;
    logic                  color_white;
    logic                  last;

    modport source (output valid, pixel_x, pixel_y, visible, color_white, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, visible, color_white, last, output ready);
endinterface

interface clr_cfg_if
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
);
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [COORD_BITS:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/clr_skid.sv =====
// Output register plus skid stage; the input waits only while the skid is full.
module clr_skid
    import clr_pkg::*;
#(
    parameter int WIDTH = 2 * COORD_BITS_DEFAULT + 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             can_push,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] skid_data_reg;

    // Control: refill the output from skid first, park a word when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/clr_core.sv =====
// Line state, configuration registers and the combinational Bresenham step.
module clr_core
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    clr_cfg_if.sink               cfg,
    clr_in_if.sink                pix_in,
    input  logic                  can_push,
    output logic                  res_valid,
    output logic [COORD_BITS-1:0] res_x,
    output logic [COORD_BITS-1:0] res_y,
    output logic                  res_visible,
    output logic                  res_white,
    output logic                  res_last
);

    localparam int ERR_BITS = COORD_BITS + 3;
    localparam int DBL_BITS = COORD_BITS + 4;

    // Configuration registers
    logic [COORD_BITS:0]   screen_width_reg;
    logic [COORD_BITS:0]   screen_height_reg;
    logic                  clip_enable_reg;
    logic [COORD_BITS-1:0] clip_left_reg;
    logic [COORD_BITS-1:0] clip_right_reg;
    logic [COORD_BITS-1:0] clip_top_reg;
    logic [COORD_BITS-1:0] clip_bottom_reg;

    // Line state
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic [COORD_BITS-1:0] span_x_reg, span_x_next;
    logic [COORD_BITS-1:0] span_y_reg, span_y_next;
    logic [ERR_BITS-1:0]   error_term_reg, error_term_next;
    logic                  step_left_reg, step_left_next;
    logic                  step_up_reg, step_up_next;
    logic                  line_active_reg, line_active_next;
    logic                  line_white_reg, line_white_next;

    logic                  accept;
    logic                  is_load;
    logic                  emit;
    logic                  at_end;
    logic                  move_x;
    logic                  move_y;
    logic signed [DBL_BITS-1:0] doubled;
    logic signed [DBL_BITS-1:0] span_x_ext;
    logic signed [DBL_BITS-1:0] span_y_ext;
    logic                  in_screen;
    logic                  in_clip;

    assign cfg.ready    = 1'b1;
    assign pix_in.ready = can_push;
    assign accept       = pix_in.valid && can_push;
    assign is_load      = (pix_in.mode == MODE_LOAD);
    assign emit         = accept && (is_load || line_active_reg);

    // Write configuration registers; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= (COORD_BITS+1)'(SCREEN_WIDTH_RESET);
            screen_height_reg <= (COORD_BITS+1)'(SCREEN_HEIGHT_RESET);
            clip_enable_reg   <= 1'b0;
            clip_left_reg     <= '0;
            clip_right_reg    <= '1;
            clip_top_reg      <= '0;
            clip_bottom_reg   <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg.data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg.data;
                REG_CLIP_ENABLE:   clip_enable_reg   <= cfg.data[0];
                REG_CLIP_LEFT:     clip_left_reg     <= cfg.data[COORD_BITS-1:0];
                REG_CLIP_RIGHT:    clip_right_reg    <= cfg.data[COORD_BITS-1:0];
                REG_CLIP_TOP:      clip_top_reg      <= cfg.data[COORD_BITS-1:0];
                REG_CLIP_BOTTOM:   clip_bottom_reg   <= cfg.data[COORD_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Bresenham decisions from the current error term
    assign doubled    = {error_term_reg, 1'b0};
    assign span_x_ext = $signed({4'b0, span_x_reg});
    assign span_y_ext = $signed({4'b0, span_y_reg});
    assign move_x     = doubled > -span_y_ext;
    assign move_y     = doubled < span_x_ext;

    // Next line state: load sets up the line, step advances one pixel
    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        goal_x_next      = goal_x_reg;
        goal_y_next      = goal_y_reg;
        span_x_next      = span_x_reg;
        span_y_next      = span_y_reg;
        error_term_next  = error_term_reg;
        step_left_next   = step_left_reg;
        step_up_next     = step_up_reg;
        line_white_next  = line_white_reg;
        if (is_load)
        begin
            step_left_next  = !(pix_in.x_start < pix_in.x_end);
            step_up_next    = !(pix_in.y_start < pix_in.y_end);
            span_x_next     = step_left_next ? pix_in.x_start - pix_in.x_end
                                             : pix_in.x_end - pix_in.x_start;
            span_y_next     = step_up_next ? pix_in.y_start - pix_in.y_end
                                           : pix_in.y_end - pix_in.y_start;
            error_term_next = {3'b0, span_x_next} - {3'b0, span_y_next};
            cur_x_next      = pix_in.x_start;
            cur_y_next      = pix_in.y_start;
            goal_x_next     = pix_in.x_end;
            goal_y_next     = pix_in.y_end;
            line_white_next = pix_in.white;
        end
        else
        begin
            error_term_next = error_term_reg
                              - (move_x ? {3'b0, span_y_reg} : ERR_BITS'(0))
                              + (move_y ? {3'b0, span_x_reg} : ERR_BITS'(0));
            if (move_x)
            begin
                cur_x_next = step_left_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (move_y)
            begin
                cur_y_next = step_up_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
        end
    end

    assign at_end           = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
    assign line_active_next = !at_end;

    // Hold line state; update only when a pixel goes out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            span_x_reg      <= '0;
            span_y_reg      <= '0;
            error_term_reg  <= '0;
            step_left_reg   <= 1'b0;
            step_up_reg     <= 1'b0;
            line_active_reg <= 1'b0;
            line_white_reg  <= 1'b0;
        end
        else if (emit)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            goal_x_reg      <= goal_x_next;
            goal_y_reg      <= goal_y_next;
            span_x_reg      <= span_x_next;
            span_y_reg      <= span_y_next;
            error_term_reg  <= error_term_next;
            step_left_reg   <= step_left_next;
            step_up_reg     <= step_up_next;
            line_active_reg <= line_active_next;
            line_white_reg  <= line_white_next;
        end
    end

    // Qualify the pixel against screen and clip rectangle
    assign in_screen = ({1'b0, cur_x_next} < screen_width_reg)
                    && ({1'b0, cur_y_next} < screen_height_reg);
    assign in_clip   = (cur_x_next >= clip_left_reg) && (cur_x_next <= clip_right_reg)
                    && (cur_y_next >= clip_top_reg) && (cur_y_next <= clip_bottom_reg);

    assign res_valid   = emit;
    assign res_x       = cur_x_next;
    assign res_y       = cur_y_next;
    assign res_visible = in_screen && (!clip_enable_reg || in_clip);
    assign res_white   = line_white_next;
    assign res_last    = at_end;

endmodule

// ===== hdl/clipped_line_rasterizer.sv =====
// Top level of the clipped line rasterizer.
//
//  channel   dir  word                                         accepted when
//  pix_in    in   mode, x_start, y_start, x_end, y_end, white  valid && ready
//  pix_out   out  pixel_x, pixel_y, visible, color_white, last valid && ready
//  cfg       in   index, data                                  valid && ready (always ready)
//
// One input word per clock while pix_in.ready is high: a load or step is resolved
// in the accepting cycle and its pixel is registered, in the skid slot if stalled.
// A step with no line in progress produces no pixel.
// The output register plus one skid slot keep pix_in.ready registered;
// pix_in stalls only when both hold a pixel. Reset clears all line state.
module clipped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    clr_in_if.sink    pix_in,
    clr_out_if.source pix_out,
    clr_cfg_if.sink   cfg
);

`include "assert_macros.svh"

    localparam int PIX_BITS = 2 * COORD_BITS + 3;

    logic                  can_push;
    logic                  res_valid;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic                  res_visible;
    logic                  res_white;
    logic                  res_last;
    logic [PIX_BITS-1:0]   out_word;

    clr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pix_in      (pix_in),
        .can_push    (can_push),
        .res_valid   (res_valid),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_visible (res_visible),
        .res_white   (res_white),
        .res_last    (res_last)
    );

    clr_skid #(
        .WIDTH (PIX_BITS)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data ({res_x, res_y, res_visible, res_white, res_last}),
        .can_push  (can_push),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_data  (out_word)
    );

    // Unpack the output word
    assign pix_out.pixel_x     = out_word[PIX_BITS-1 -: COORD_BITS];
    assign pix_out.pixel_y     = out_word[COORD_BITS+2 -: COORD_BITS];
    assign pix_out.visible     = out_word[2];
    assign pix_out.color_white = out_word[1];
    assign pix_out.last        = out_word[0];

    // A stalled input means a pixel is waiting at the output
    `ASSERT_IMPLIES(a_stall_has_pixel, clk, rst_n, !pix_in.ready, pix_out.valid)
    // Every accepted load produces a pixel
    `ASSERT_IMPLIES(a_load_emits, clk, rst_n,
        pix_in.valid && pix_in.ready && pix_in.mode == MODE_LOAD, res_valid)
    // A pixel pushed into an empty output shows up next cycle
    `ASSERT_NEXT(a_push_shows, clk, rst_n, res_valid && !pix_out.valid, pix_out.valid)

endmodule
